FILE: rtl/core/y2r_pkg.sv
// ----------------------------------------------------------------------------
// y2r_pkg
// Types and fixed coefficients shared by the YUV to RGB pixel converter.
// ----------------------------------------------------------------------------
package y2r_pkg;

  localparam int CFG_IDX_W = 4;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FULL_RANGE  = 4'd0,
    REG_USE_BT709   = 4'd1,
    REG_SWAP_CHROMA = 4'd2,
    REG_OUT_FORMAT  = 4'd3
  } cfg_reg_t;

  typedef struct packed {
    logic full_range;
    logic use_bt709;
    logic swap_chroma;
    logic out_format;
  } cfg_t;

  typedef struct packed {
    logic [7:0] luma;
    logic [7:0] chroma_first;
    logic [7:0] chroma_second;
  } pix_t;

  typedef struct packed {
    logic [31:0] pixel_word;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } rgb_t;

  // Arithmetic width: every intermediate fits in 20 signed bits.
  localparam int AW = 20;

  // Limited-range luma gain and offsets
  localparam logic signed [AW-1:0] K_Y         = 20'sd298;
  localparam logic signed [AW-1:0] LUMA_OFS    = 20'sd16;
  localparam logic signed [AW-1:0] CHROMA_OFS  = 20'sd128;
  localparam logic signed [AW-1:0] RND_LIM     = 20'sd128;
  localparam logic signed [AW-1:0] RND_FULL    = 20'sd512;

  // BT.601 limited range
  localparam logic signed [AW-1:0] K601_RV = 20'sd409;
  localparam logic signed [AW-1:0] K601_GU = 20'sd100;
  localparam logic signed [AW-1:0] K601_GV = 20'sd208;
  localparam logic signed [AW-1:0] K601_BU = 20'sd516;

  // BT.709 limited range
  localparam logic signed [AW-1:0] K709_RV = 20'sd459;
  localparam logic signed [AW-1:0] K709_GU = 20'sd55;
  localparam logic signed [AW-1:0] K709_GV = 20'sd137;
  localparam logic signed [AW-1:0] K709_BU = 20'sd541;

  // Full-range JPEG, scaled by 1024
  localparam logic signed [AW-1:0] KF_RV = 20'sd1436;
  localparam logic signed [AW-1:0] KF_GU = 20'sd352;
  localparam logic signed [AW-1:0] KF_GV = 20'sd731;
  localparam logic signed [AW-1:0] KF_BU = 20'sd1814;

  localparam logic [7:0] ALPHA = 8'hFF;

endpackage

FILE: rtl/core/y2r_ifs.sv
// ----------------------------------------------------------------------------
// y2r channel interfaces
// Valid/ready channels for pixels in, RGB results out and register writes.
// ----------------------------------------------------------------------------
interface y2r_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma;
  logic [7:0] chroma_first;
  logic [7:0] chroma_second;

  modport source (output valid, luma, chroma_first, chroma_second, input ready);
  modport sink   (input valid, luma, chroma_first, chroma_second, output ready);
endinterface

interface y2r_rgb_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_word;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;

  modport source (output valid, pixel_word, red, green, blue, input ready);
  modport sink   (input valid, pixel_word, red, green, blue, output ready);
endinterface

interface y2r_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [y2r_pkg::CFG_IDX_W-1:0] index;
  logic                          data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/y2r_matrix.sv
// ----------------------------------------------------------------------------
// y2r_matrix
// Colour matrix, clamp and packing for one pixel; purely combinational.
// ----------------------------------------------------------------------------
module y2r_matrix (
  input  y2r_pkg::cfg_t cfg,
  input  y2r_pkg::pix_t pix,
  output y2r_pkg::rgb_t rgb
);
  import y2r_pkg::*;

  logic [7:0] u;
  logic [7:0] v;
  logic signed [AW-1:0] y_s, c_s, du, dv;
  logic signed [AW-1:0] k_rv, k_gu, k_gv, k_bu;
  logic signed [AW-1:0] r_lim, g_lim, b_lim;
  logic signed [AW-1:0] r_full, g_full, b_full;
  logic signed [AW-1:0] r_wide, g_wide, b_wide;
  logic [7:0] r8, g8, b8;

  function automatic logic [7:0] sat8(input logic signed [AW-1:0] val);
    logic [7:0] res;
    if (val < 0) begin
      res = 8'd0;
    end else if (val > 20'sd255) begin
      res = 8'hFF;
    end else begin
      res = val[7:0];
    end
    return res;
  endfunction

  assign u = cfg.swap_chroma ? pix.chroma_second : pix.chroma_first;
  assign v = cfg.swap_chroma ? pix.chroma_first  : pix.chroma_second;

  assign y_s = {{(AW-8){1'b0}}, pix.luma};
  assign c_s = y_s - LUMA_OFS;
  assign du  = $signed({{(AW-8){1'b0}}, u}) - CHROMA_OFS;
  assign dv  = $signed({{(AW-8){1'b0}}, v}) - CHROMA_OFS;

  assign k_rv = cfg.use_bt709 ? K709_RV : K601_RV;
  assign k_gu = cfg.use_bt709 ? K709_GU : K601_GU;
  assign k_gv = cfg.use_bt709 ? K709_GV : K601_GV;
  assign k_bu = cfg.use_bt709 ? K709_BU : K601_BU;

  // Arithmetic right shift of a signed value is the floor division needed here.
  assign r_lim = (K_Y * c_s + k_rv * dv + RND_LIM) >>> 8;
  assign g_lim = (K_Y * c_s - k_gu * du - k_gv * dv + RND_LIM) >>> 8;
  assign b_lim = (K_Y * c_s + k_bu * du + RND_LIM) >>> 8;

  assign r_full = y_s + ((KF_RV * dv + RND_FULL) >>> 10);
  assign g_full = y_s - ((KF_GU * du + KF_GV * dv + RND_FULL) >>> 10);
  assign b_full = y_s + ((KF_BU * du + RND_FULL) >>> 10);

  assign r_wide = cfg.full_range ? r_full : r_lim;
  assign g_wide = cfg.full_range ? g_full : g_lim;
  assign b_wide = cfg.full_range ? b_full : b_lim;

  assign r8 = sat8(r_wide);
  assign g8 = sat8(g_wide);
  assign b8 = sat8(b_wide);

  always_comb begin
    rgb.red   = r8;
    rgb.green = g8;
    rgb.blue  = b8;
    if (cfg.out_format) begin
      rgb.pixel_word = {ALPHA, r8, g8, b8};
    end else begin
      rgb.pixel_word = {16'd0, r8[7:3], g8[7:2], b8[7:3]};
    end
  end

endmodule

FILE: rtl/core/yuv_to_rgb_pixel_converter.sv
// ----------------------------------------------------------------------------
// yuv_to_rgb_pixel_converter
// Converts one YUV pixel per cycle, if unstalled, to clamped RGB565 or XRGB8888.
// ----------------------------------------------------------------------------
// A pixel is captured in the input register, passes through the matrix and is
// held in the result register, from which it is offered on rgb_out.
// Throughput: one pixel per cycle unless rgb_out holds back; an input register
// and a result register carry the pipeline, with the combinational matrix between.
// Reset (rst, synchronous, active high) empties both stages and loads the
// registers with full_range 0, use_bt709 1, swap_chroma 0, out_format 1.
module yuv_to_rgb_pixel_converter (
  input logic     clk,
  input logic     rst,
  y2r_pix_if.sink pix_in,
  y2r_rgb_if.source rgb_out,
  y2r_cfg_if.sink cfg
);
  import y2r_pkg::*;

  cfg_t cfg_q;
  pix_t pix_q;
  rgb_t rgb_d;
  rgb_t rgb_q;
  logic v1;
  logic v2;
  logic adv1;
  logic adv2;

  // Register writes are always taken; an unknown index has no effect.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.full_range  <= 1'b0;
      cfg_q.use_bt709   <= 1'b1;
      cfg_q.swap_chroma <= 1'b0;
      cfg_q.out_format  <= 1'b1;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_FULL_RANGE:  cfg_q.full_range  <= cfg.data;
        REG_USE_BT709:   cfg_q.use_bt709   <= cfg.data;
        REG_SWAP_CHROMA: cfg_q.swap_chroma <= cfg.data;
        REG_OUT_FORMAT:  cfg_q.out_format  <= cfg.data;
        default: ;
      endcase
    end
  end

  // A stage moves on when the stage after it is empty or being drained.
  assign adv2 = !v2 || rgb_out.ready;
  assign adv1 = !v1 || adv2;
  assign pix_in.ready = adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (adv1) begin
        v1 <= pix_in.valid;
      end
      if (adv2) begin
        v2 <= v1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1 && pix_in.valid) begin
      pix_q.luma          <= pix_in.luma;
      pix_q.chroma_first  <= pix_in.chroma_first;
      pix_q.chroma_second <= pix_in.chroma_second;
    end
    if (adv2 && v1) begin
      rgb_q <= rgb_d;
    end
  end

  y2r_matrix u_matrix (
    .cfg (cfg_q),
    .pix (pix_q),
    .rgb (rgb_d)
  );

  assign rgb_out.valid      = v2;
  assign rgb_out.pixel_word = rgb_q.pixel_word;
  assign rgb_out.red        = rgb_q.red;
  assign rgb_out.green      = rgb_q.green;
  assign rgb_out.blue       = rgb_q.blue;

endmodule

FILE: rtl/core/y2r_checker.sv
// ----------------------------------------------------------------------------
// y2r_checker
// Port-level checks on the converter's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module y2r_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] pixel_word,
  input logic [7:0]  red,
  input logic [7:0]  green,
  input logic [7:0]  blue
);

  // A result on offer stays on offer until it is transferred.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before transfer");

  // Nothing is offered in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered straight after reset");

  // The packed word is one of the two formats.
  a_word_form: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pixel_word[31:24] == 8'hFF || pixel_word[31:16] == 16'd0))
    else $error("pixel word has neither alpha nor a clear upper half");

  // The packed word agrees with the separate channels.
  a_word_match: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pixel_word == {8'hFF, red, green, blue} ||
                   pixel_word == {16'd0, red[7:3], green[7:2], blue[7:3]}))
    else $error("pixel word disagrees with red, green and blue");

endmodule

bind yuv_to_rgb_pixel_converter y2r_checker u_y2r_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (rgb_out.valid),
  .out_ready  (rgb_out.ready),
  .pixel_word (rgb_out.pixel_word),
  .red        (rgb_out.red),
  .green      (rgb_out.green),
  .blue       (rgb_out.blue)
);

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the YUV to RGB pixel converter. Pixels are
// streamed through under many register settings, with random gaps on
// the input and random back-pressure on the output. A scoreboard works
// out each expected RGB result on its own and compares every transfer
// that leaves the block, field by field and in order.
// ----------------------------------------------------------------------------
module tb_top;
  import y2r_pkg::*;

  localparam int NUM_REGS      = 4;
  localparam int RANDOM_ITEMS  = 1550;
  localparam int PIPE_LATENCY  = 2;
  localparam int MAX_GAP       = 16;
  localparam int HOLD_CYCLES   = 250;
  localparam int PRESSURE_LEN  = 300;

  localparam pix_t CORNER_PIX [6] = '{
    '{8'd0,   8'd0,   8'd0},
    '{8'd255, 8'd255, 8'd255},
    '{8'd16,  8'd128, 8'd128},
    '{8'd235, 8'd0,   8'd255},
    '{8'd128, 8'd255, 8'd0},
    '{8'd255, 8'd0,   8'd128}
  };

  class pixel_scoreboard;
    cfg_t settings = '{full_range: 1'b0, use_bt709: 1'b1, swap_chroma: 1'b0,
                       out_format: 1'b1};
    rgb_t pending_rgb [$];
    int   errors = 0;

    function logic [7:0] clamp8(int v);
      if (v < 0) return 8'd0;
      if (v > 255) return 8'd255;
      return v[7:0];
    endfunction

    // Arithmetic shifts on int give the floor division the matrices need.
    function rgb_t convert_pixel(pix_t p);
      int y, u, v, c, d, e, rr, gg, bb;
      logic [7:0] r, g, b;
      rgb_t res;
      y = p.luma;
      u = settings.swap_chroma ? p.chroma_second : p.chroma_first;
      v = settings.swap_chroma ? p.chroma_first : p.chroma_second;
      d = u - 128;
      e = v - 128;
      if (settings.full_range) begin
        rr = y + ((1436 * e + 512) >>> 10);
        gg = y - ((352 * d + 731 * e + 512) >>> 10);
        bb = y + ((1814 * d + 512) >>> 10);
      end else begin
        c = y - 16;
        if (settings.use_bt709) begin
          rr = (298 * c + 459 * e + 128) >>> 8;
          gg = (298 * c - 55 * d - 137 * e + 128) >>> 8;
          bb = (298 * c + 541 * d + 128) >>> 8;
        end else begin
          rr = (298 * c + 409 * e + 128) >>> 8;
          gg = (298 * c - 100 * d - 208 * e + 128) >>> 8;
          bb = (298 * c + 516 * d + 128) >>> 8;
        end
      end
      r = clamp8(rr);
      g = clamp8(gg);
      b = clamp8(bb);
      res.red   = r;
      res.green = g;
      res.blue  = b;
      if (settings.out_format) res.pixel_word = {ALPHA, r, g, b};
      else res.pixel_word = {16'h0000, r[7:3], g[7:2], b[7:3]};
      return res;
    endfunction

    function void note_pixel(pix_t p);
      pending_rgb.push_back(convert_pixel(p));
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      end
    endfunction

    function void check_result(rgb_t got);
      rgb_t want;
      if (pending_rgb.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      want = pending_rgb.pop_front();
      compare_field("pixel_word", want.pixel_word, got.pixel_word);
      compare_field("red", {24'h0, want.red}, {24'h0, got.red});
      compare_field("green", {24'h0, want.green}, {24'h0, got.green});
      compare_field("blue", {24'h0, want.blue}, {24'h0, got.blue});
    endfunction
  endclass

  logic clk;
  logic rst;

  y2r_pix_if pix_in ();
  y2r_rgb_if rgb_out ();
  y2r_cfg_if cfg ();

  yuv_to_rgb_pixel_converter dut (
    .clk     (clk),
    .rst     (rst),
    .pix_in  (pix_in.sink),
    .rgb_out (rgb_out.source),
    .cfg     (cfg.sink)
  );

  pixel_scoreboard sb = new();

  bit hold_output = 1'b0;
  bit src_steady  = 1'b0;
  int src_count   = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("FAILURE");
    $finish;
  end

  function logic [7:0] random_sample();
    if ($urandom_range(0, 5) == 0) begin
      case ($urandom_range(0, 4))
        0: return 8'd0;
        1: return 8'd255;
        2: return 8'd16;
        3: return 8'd235;
        default: return 8'd128;
      endcase
    end
    return 8'($urandom_range(0, 255));
  endfunction

  function pix_t random_pixel();
    pix_t p;
    p.luma          = random_sample();
    p.chroma_first  = random_sample();
    p.chroma_second = random_sample();
    return p;
  endfunction

  // The valid line is left high after a transfer so that back-to-back
  // pixels need no second assignment in the same step.
  task automatic send_pixel(pix_t p);
    int gap;
    if (src_count % 64 == 0) src_steady = ($urandom_range(0, 3) == 0);
    src_count++;
    gap = src_steady ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      pix_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_in.valid         <= 1'b1;
    pix_in.luma          <= p.luma;
    pix_in.chroma_first  <= p.chroma_first;
    pix_in.chroma_second <= p.chroma_second;
    do @(posedge clk); while (!pix_in.ready);
    sb.note_pixel(p);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      REG_FULL_RANGE:  sb.settings.full_range  = val;
      REG_USE_BT709:   sb.settings.use_bt709   = val;
      REG_SWAP_CHROMA: sb.settings.swap_chroma = val;
      REG_OUT_FORMAT:  sb.settings.out_format  = val;
      default: ;
    endcase
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_settings(cfg_t s);
    write_reg(REG_FULL_RANGE, s.full_range);
    write_reg(REG_USE_BT709, s.use_bt709);
    write_reg(REG_SWAP_CHROMA, s.swap_chroma);
    write_reg(REG_OUT_FORMAT, s.out_format);
  endtask

  // A write to an index past the register list must leave every setting alone.
  task automatic write_unmapped();
    write_reg(CFG_IDX_W'($urandom_range(NUM_REGS, (1 << CFG_IDX_W) - 1)),
              1'($urandom_range(0, 1)));
  endtask

  task automatic settle();
    pix_in.valid <= 1'b0;
    while (sb.pending_rgb.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  task automatic send_corners();
    foreach (CORNER_PIX[i]) send_pixel(CORNER_PIX[i]);
    settle();
  endtask

  // Result side: random back-pressure, plus one long hold on request.
  initial begin
    int   gap;
    int   seen;
    bit   steady;
    rgb_t got;
    seen = 0;
    steady = 1'b0;
    rgb_out.ready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_output) begin
        hold_output = 1'b0;
        rgb_out.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (seen % 64 == 0) steady = ($urandom_range(0, 3) == 0);
      gap = steady ? 0 : $urandom_range(0, MAX_GAP);
      if (gap != 0) begin
        rgb_out.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rgb_out.ready <= 1'b1;
      do @(posedge clk); while (!rgb_out.valid);
      got.pixel_word = rgb_out.pixel_word;
      got.red        = rgb_out.red;
      got.green      = rgb_out.green;
      got.blue       = rgb_out.blue;
      sb.check_result(got);
      seen++;
    end
  end

  initial begin
    int   sent;
    int   phase;
    int   phase_len;
    cfg_t s;
    rst                  = 1'b1;
    pix_in.valid         = 1'b0;
    pix_in.luma          = '0;
    pix_in.chroma_first  = '0;
    pix_in.chroma_second = '0;
    cfg.valid            = 1'b0;
    cfg.index            = '0;
    cfg.data             = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Corner pixels under the reset settings and three others.
    send_corners();
    write_unmapped();
    apply_settings('{full_range: 1'b1, use_bt709: 1'b0, swap_chroma: 1'b1,
                     out_format: 1'b0});
    send_corners();
    apply_settings('{full_range: 1'b0, use_bt709: 1'b0, swap_chroma: 1'b1,
                     out_format: 1'b1});
    send_corners();
    apply_settings('{full_range: 1'b0, use_bt709: 1'b0, swap_chroma: 1'b0,
                     out_format: 1'b0});
    send_corners();

    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      s = cfg_t'($urandom_range(0, 15));
      if (phase == 0) s = '0;
      if (phase == 1) s = '1;
      apply_settings(s);
      if ($urandom_range(0, 2) == 0) write_unmapped();
      phase_len = (phase == 2) ? PRESSURE_LEN : $urandom_range(40, 200);
      for (int i = 0; i < phase_len; i++) begin
        // A third of the way through this phase the output stalls while pixels keep coming.
        if (phase == 2 && i == 100) hold_output = 1'b1;
        send_pixel(random_pixel());
        sent++;
      end
      settle();
      phase++;
    end

    if (sb.errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
